[rtl/core/spi_slave_fixed_frame_mailbox_defines.svh]
// Assertion macros shared by the mailbox RTL.
`ifndef SPI_SLAVE_FIXED_FRAME_MAILBOX_DEFINES_SVH
`define SPI_SLAVE_FIXED_FRAME_MAILBOX_DEFINES_SVH
`ifndef SYNTHESIS
`define SFFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox assertion failed");
`define SFFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox assertion failed");
`else
`define SFFM_ASSERT_NOW(label, ante, cons)
`define SFFM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/sffm_pkg.sv]
package sffm_pkg;

    localparam int FRAME_BYTES_DEF = 32;
    localparam int REQ_W           = 3;
    localparam int BYTE_W          = 8;
    localparam int IDX_W           = 5;
    localparam int CNT_W           = 32;
    localparam int QUEUE_DEPTH     = 3;
    localparam int QCNT_W          = 2;
    localparam int QPTR_W          = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_EXCHANGE = 3'd0,
        REQ_OVERRUN  = 3'd1,
        REQ_STAGE    = 3'd2,
        REQ_COMMIT   = 3'd3,
        REQ_READ     = 3'd4,
        REQ_RELEASE  = 3'd5,
        REQ_START    = 3'd6,
        REQ_STOP     = 3'd7
    } req_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic swap;
        logic restart;
        logic keep;
    } tx_cmd_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic flip;
        logic restart;
    } rx_cmd_t;

    typedef struct packed {
        logic               src_tx;
        logic               src_rx;
        logic               accepted;
        logic               frame_done;
        logic               rx_avail;
        logic               tx_pending;
        logic               running;
        logic [IDX_W-1:0]   frame_position;
        logic [CNT_W-1:0]   frames_count;
        logic [CNT_W-1:0]   overrun_count;
        logic [CNT_W-1:0]   byte_count;
    } stage_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               accepted;
        logic               frame_done;
        logic               rx_avail;
        logic               tx_pending;
        logic               running;
        logic [IDX_W-1:0]   frame_position;
        logic [CNT_W-1:0]   frames_count;
        logic [CNT_W-1:0]   overrun_count;
        logic [CNT_W-1:0]   byte_count;
    } res_t;

endpackage

[rtl/core/sffm_tx_store.sv]
module sffm_tx_store
    import sffm_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tx_cmd_t                        cmd,
    input  logic [$clog2(FRAME_BYTES)-1:0] addr,
    input  logic [BYTE_W-1:0]              wdata,
    output logic [BYTE_W-1:0]              rdata,
    output logic                           zero
);

    localparam int POS_W     = $clog2(FRAME_BYTES);
    localparam int ADDR_W    = POS_W + 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Each position has two physical slots. The current and staged frames each
    // point at one slot, or read as zero, so a swap only moves the pointers.
    logic [BYTE_W-1:0] mem [0:MEM_DEPTH-1];
    logic              cur_slot_reg [0:FRAME_BYTES-1];
    logic              stg_slot_reg [0:FRAME_BYTES-1];
    logic              cur_zero_reg [0:FRAME_BYTES-1];
    logic              stg_zero_reg [0:FRAME_BYTES-1];
    logic [BYTE_W-1:0] rdata_reg;
    logic              zero_reg;
    logic              wr_slot;

    assign wr_slot = cur_zero_reg[addr] ? stg_slot_reg[addr] : ~cur_slot_reg[addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                cur_slot_reg[i] <= 1'b0;
                stg_slot_reg[i] <= 1'b0;
                cur_zero_reg[i] <= 1'b1;
                stg_zero_reg[i] <= 1'b1;
            end
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                if (cmd.keep)
                begin
                    cur_slot_reg[i] <= stg_slot_reg[i];
                    cur_zero_reg[i] <= stg_zero_reg[i];
                end
                else
                begin
                    cur_zero_reg[i] <= 1'b1;
                end
                stg_zero_reg[i] <= 1'b1;
            end
        end
        else if (cmd.swap)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                cur_slot_reg[i] <= stg_slot_reg[i];
                cur_zero_reg[i] <= stg_zero_reg[i];
            end
        end
        else if (cmd.wr)
        begin
            stg_slot_reg[addr] <= wr_slot;
            stg_zero_reg[addr] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[{wr_slot, addr}] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[{cur_slot_reg[addr], addr}];
            zero_reg  <= cur_zero_reg[addr];
        end
    end

    assign rdata = rdata_reg;
    assign zero  = zero_reg;

endmodule

[rtl/core/sffm_rx_store.sv]
module sffm_rx_store
    import sffm_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rx_cmd_t                        cmd,
    input  logic [$clog2(FRAME_BYTES)-1:0] addr,
    input  logic [BYTE_W-1:0]              wdata,
    output logic [BYTE_W-1:0]              rdata,
    output logic                           valid
);

    localparam int POS_W     = $clog2(FRAME_BYTES);
    localparam int ADDR_W    = POS_W + 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Two banks: one fills while the other holds the ready frame.
    logic [BYTE_W-1:0] mem [0:MEM_DEPTH-1];
    logic              fill_sel_reg;
    logic              ready_valid_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_sel_reg    <= 1'b0;
            ready_valid_reg <= 1'b0;
        end
        else if (cmd.restart)
        begin
            ready_valid_reg <= 1'b0;
        end
        else if (cmd.flip)
        begin
            fill_sel_reg    <= ~fill_sel_reg;
            ready_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[{fill_sel_reg, addr}] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[{~fill_sel_reg, addr}];
            valid_reg <= ready_valid_reg;
        end
    end

    assign rdata = rdata_reg;
    assign valid = valid_reg;

endmodule

[rtl/core/sffm_out_queue.sv]
`include "spi_slave_fixed_frame_mailbox_defines.svh"

module sffm_out_queue
    import sffm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  res_t              push_data,
    input  logic              pop,
    output logic              not_empty,
    output res_t              head,
    output logic [QCNT_W-1:0] count
);

    res_t              entry_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    `SFFM_ASSERT_NOW(a_no_push_when_full, push, count_reg < QCNT_W'(QUEUE_DEPTH))

endmodule

[rtl/core/spi_slave_fixed_frame_mailbox.sv]
// Frame engine for an SPI slave that exchanges fixed frames of FRAME_BYTES bytes.
// Requests enter on the s_ channel: s_tuser holds the request type, s_tdata the
// received byte, the byte index and the staged byte. Every request gives exactly
// one response on the m_ channel with the output byte, the accepted flag, the
// engine flags, the frame position and the three counters; m_tlast marks the
// exchange that completed a frame.
// A request is taken in the cycle it is offered when there is room, so one
// request per cycle is sustained while the receiver takes every response. The
// response passes through the synchronous frame memory read and then the
// response register queue.
// Transmit frames sit in a two-slot memory with per-position slot pointers, and
// received frames in a two-bank memory, so frame swaps need no copying.
// After reset the engine is stopped, all frames read as zero and counters are
// zero. When the receiver stalls, up to three responses are held and s_tready
// drops until a response is taken; no response is lost.
`include "spi_slave_fixed_frame_mailbox_defines.svh"

module spi_slave_fixed_frame_mailbox
    import sffm_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // rx_byte[7:0], byte_index[12:8], write_byte[20:13]
    input  logic [2:0]   s_tuser,   // req_type[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // out_byte[7:0], accepted[8], rx_avail[9],
                                    // tx_pending[10], running[11], frame_position[16:12],
                                    // frames_count[48:17], overrun_count[80:49],
                                    // byte_count[112:81]
    output logic         m_tlast    // frame_done
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam int EXT_W = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    req_t              req;
    logic [BYTE_W-1:0] rx_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] write_byte;
    logic              s_accept;
    logic              idx_ok;
    logic [EXT_W-1:0]  idx_ext;
    logic [POS_W-1:0]  idx_addr;
    logic [EXT_W-1:0]  pos_ext;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              run_reg, run_next;
    logic              pending_reg, pending_next;
    logic              ready_reg, ready_next;
    logic [CNT_W-1:0]  frames_reg, frames_next;
    logic [CNT_W-1:0]  overruns_reg, overruns_next;
    logic [CNT_W-1:0]  bytes_reg, bytes_next;

    logic              p1_valid_reg;
    stage_t            p1_reg, p1_next;

    tx_cmd_t           tx_cmd;
    rx_cmd_t           rx_cmd;
    logic [POS_W-1:0]  tx_addr;
    logic [POS_W-1:0]  rx_addr;
    logic [BYTE_W-1:0] tx_rdata;
    logic              tx_zero;
    logic [BYTE_W-1:0] rx_rdata;
    logic              rx_valid;

    res_t              res;
    res_t              head;
    logic [QCNT_W-1:0] q_count;
    logic [2:0]        occ;
    logic              m_accept;

    assign req        = req_t'(s_tuser);
    assign rx_byte    = s_tdata[7:0];
    assign byte_index = s_tdata[12:8];
    assign write_byte = s_tdata[20:13];

    assign occ      = 3'(q_count) + 3'(p1_valid_reg);
    assign s_tready = (occ < 3'(QUEUE_DEPTH));
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    assign idx_ok   = (32'(byte_index) < FRAME_BYTES);
    assign idx_ext  = EXT_W'(byte_index);
    assign idx_addr = idx_ext[POS_W-1:0];

    always_comb
    begin
        pos_next      = pos_reg;
        run_next      = run_reg;
        pending_next  = pending_reg;
        ready_next    = ready_reg;
        frames_next   = frames_reg;
        overruns_next = overruns_reg;
        bytes_next    = bytes_reg;
        tx_cmd        = '0;
        rx_cmd        = '0;
        tx_addr       = pos_reg;
        rx_addr       = pos_reg;
        p1_next       = '0;

        if (s_accept)
        begin
            unique case (req)
                REQ_EXCHANGE:
                begin
                    if (run_reg)
                    begin
                        p1_next.accepted = 1'b1;
                        p1_next.src_tx   = 1'b1;
                        tx_cmd.rd        = 1'b1;
                        rx_cmd.wr        = 1'b1;
                        bytes_next       = bytes_reg + CNT_W'(1);
                        if (pos_reg == POS_LAST)
                        begin
                            p1_next.frame_done = 1'b1;
                            rx_cmd.flip        = 1'b1;
                            ready_next         = 1'b1;
                            frames_next        = frames_reg + CNT_W'(1);
                            pos_next           = '0;
                            tx_cmd.swap        = pending_reg;
                            pending_next       = 1'b0;
                        end
                        else
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                end
                REQ_OVERRUN:
                begin
                    if (run_reg)
                    begin
                        p1_next.accepted = 1'b1;
                        overruns_next    = overruns_reg + CNT_W'(1);
                        pos_next         = '0;
                        tx_cmd.swap      = pending_reg;
                        pending_next     = 1'b0;
                    end
                end
                REQ_STAGE:
                begin
                    tx_addr = idx_addr;
                    if (idx_ok)
                    begin
                        p1_next.accepted = 1'b1;
                        tx_cmd.wr        = 1'b1;
                    end
                end
                REQ_COMMIT:
                begin
                    if (run_reg)
                    begin
                        p1_next.accepted = 1'b1;
                        pending_next     = 1'b1;
                    end
                end
                REQ_READ:
                begin
                    rx_addr = idx_addr;
                    if (idx_ok)
                    begin
                        p1_next.accepted = 1'b1;
                        p1_next.src_rx   = 1'b1;
                        rx_cmd.rd        = 1'b1;
                    end
                end
                REQ_RELEASE:
                begin
                    p1_next.accepted = ready_reg;
                    ready_next       = 1'b0;
                end
                REQ_START:
                begin
                    p1_next.accepted = 1'b1;
                    tx_cmd.restart   = 1'b1;
                    tx_cmd.keep      = pending_reg;
                    rx_cmd.restart   = 1'b1;
                    pos_next         = '0;
                    pending_next     = 1'b0;
                    ready_next       = 1'b0;
                    frames_next      = '0;
                    overruns_next    = '0;
                    bytes_next       = '0;
                    run_next         = 1'b1;
                end
                REQ_STOP:
                begin
                    p1_next.accepted = run_reg;
                    run_next         = 1'b0;
                end
                default:
                begin
                    p1_next.accepted = 1'b0;
                end
            endcase
        end

        pos_ext                = EXT_W'(pos_next);
        p1_next.rx_avail       = ready_next;
        p1_next.tx_pending     = pending_next;
        p1_next.running        = run_next;
        p1_next.frame_position = pos_ext[IDX_W-1:0];
        p1_next.frames_count   = frames_next;
        p1_next.overrun_count  = overruns_next;
        p1_next.byte_count     = bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            run_reg      <= 1'b0;
            pending_reg  <= 1'b0;
            ready_reg    <= 1'b0;
            frames_reg   <= '0;
            overruns_reg <= '0;
            bytes_reg    <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            run_reg      <= run_next;
            pending_reg  <= pending_next;
            ready_reg    <= ready_next;
            frames_reg   <= frames_next;
            overruns_reg <= overruns_next;
            bytes_reg    <= bytes_next;
            p1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p1_reg <= p1_next;
        end
    end

    sffm_tx_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_tx_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tx_cmd),
        .addr  (tx_addr),
        .wdata (write_byte),
        .rdata (tx_rdata),
        .zero  (tx_zero)
    );

    sffm_rx_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_rx_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rx_cmd),
        .addr  (rx_addr),
        .wdata (rx_byte),
        .rdata (rx_rdata),
        .valid (rx_valid)
    );

    always_comb
    begin
        res.out_byte = '0;
        if (p1_reg.src_tx && !tx_zero)
        begin
            res.out_byte = tx_rdata;
        end
        else if (p1_reg.src_rx && rx_valid)
        begin
            res.out_byte = rx_rdata;
        end
        res.accepted       = p1_reg.accepted;
        res.frame_done     = p1_reg.frame_done;
        res.rx_avail       = p1_reg.rx_avail;
        res.tx_pending     = p1_reg.tx_pending;
        res.running        = p1_reg.running;
        res.frame_position = p1_reg.frame_position;
        res.frames_count   = p1_reg.frames_count;
        res.overrun_count  = p1_reg.overrun_count;
        res.byte_count     = p1_reg.byte_count;
    end

    sffm_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p1_valid_reg),
        .push_data (res),
        .pop       (m_accept),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (q_count)
    );

    assign m_tdata = {7'd0, head.byte_count, head.overrun_count, head.frames_count,
                      head.frame_position, head.running, head.tx_pending,
                      head.rx_avail, head.accepted, head.out_byte};
    assign m_tlast = head.frame_done;

    `SFFM_ASSERT_NEXT(a_frame_wrap,
        s_accept && req == REQ_EXCHANGE && run_reg && pos_reg == POS_LAST,
        pos_reg == '0 && ready_reg && p1_reg.frame_done)
    `SFFM_ASSERT_NOW(a_occupancy, p1_valid_reg, 3'(q_count) < 3'(QUEUE_DEPTH))
    `SFFM_ASSERT_NEXT(a_start_clears, s_accept && req == REQ_START,
        run_reg && !pending_reg && !ready_reg && pos_reg == '0 &&
        frames_reg == '0 && overruns_reg == '0 && bytes_reg == '0)

endmodule
